// ===== rtl/core/lsseg_pkg.sv =====
// ----------------------------------------------------------------------------
// USB line-state segmenter package
// Shared types, register indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package lsseg_pkg;

   // Fixed field widths of the ports.
   localparam int LEVEL_PORT_BITS = 16;
   localparam int START_PORT_BITS = 48;
   localparam int LEN_PORT_BITS   = 32;
   localparam int SEG_PORT_BITS   = 48;

   // Register widths.
   localparam int THRESHOLD_BITS = 16;
   localparam int TICK_BITS      = 32;
   localparam int GLITCH_BITS    = 40;
   localparam int CSR_DATA_BITS  = GLITCH_BITS;
   localparam int CSR_INDEX_BITS = 2;

   // ceil(glitch / tick) fits in one bit more than the glitch limit.
   localparam int NEED_BITS = GLITCH_BITS + 1;

   // Default build parameters.
   localparam int DEFAULT_TIME_BITS  = 48;
   localparam int DEFAULT_LEVEL_BITS = 16;

   // Depth of the queue between the classifier and the merge stage.
   localparam int QUEUE_DEPTH = 2;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FULL_SPEED = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICK       = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GLITCH     = 2'd3;

   // Register reset values.
   localparam logic                      FULL_SPEED_RESET = 1'b1;
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET  = 16'd400;
   localparam logic [TICK_BITS-1:0]      TICK_RESET       = 32'd1;
   localparam logic [GLITCH_BITS-1:0]    GLITCH_RESET     = 40'd100000;
   // ceil(GLITCH_RESET / TICK_RESET)
   localparam logic [NEED_BITS-1:0]      NEED_RESET       = 41'd100000;

   // Word action codes.
   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_FLUSH  = 1'b1;

   typedef enum logic [1:0] {
      LS_SE0 = 2'd0,
      LS_SE1 = 2'd1,
      LS_J   = 2'd2,
      LS_K   = 2'd3
   } line_state_type;

   // Glitch test operand prepared from tick and glitch limit.
   typedef struct packed {
      logic                 always_short;
      logic [NEED_BITS-1:0] need;
   } need_type;

   // Merge stage status, for checking.
   typedef struct packed {
      logic pop;
      logic pop_flush;
      logic open_valid;
   } back_status_type;

endpackage

// ===== rtl/core/lsseg_front.sv =====
// ----------------------------------------------------------------------------
// Line-state classifier
// Slices D+ and D- against the threshold and classes the pair as SE0, SE1,
// J or K; sizes start and length to the internal time width.
// ----------------------------------------------------------------------------
module lsseg_front
   import lsseg_pkg::*;
#(
   parameter int TIME_BITS  = DEFAULT_TIME_BITS,
   parameter int LEVEL_BITS = DEFAULT_LEVEL_BITS
) (
   input  logic signed [LEVEL_PORT_BITS-1:0] dp_level,
   input  logic signed [LEVEL_PORT_BITS-1:0] dn_level,
   input  logic [THRESHOLD_BITS-1:0]         threshold,
   input  logic                              full_speed,
   input  logic [START_PORT_BITS-1:0]        sample_start,
   input  logic [LEN_PORT_BITS-1:0]          sample_len,
   output line_state_type                    line_state,
   output logic [TIME_BITS-1:0]              start_t,
   output logic [TIME_BITS-1:0]              len_t
);

   logic signed [LEVEL_BITS-1:0] dp_s;
   logic signed [LEVEL_BITS-1:0] dn_s;
   logic signed [LEVEL_BITS-1:0] thr_s;
   logic                         dp_high;
   logic                         dn_high;

   // Fields are taken at their port width, then read as LEVEL_BITS two's complement.
   assign dp_s  = LEVEL_BITS'($unsigned(dp_level));
   assign dn_s  = LEVEL_BITS'($unsigned(dn_level));
   assign thr_s = LEVEL_BITS'(threshold);

   assign dp_high = dp_s > thr_s;
   assign dn_high = dn_s > thr_s;

   always_comb begin
      priority if (dp_high && dn_high) begin
         line_state = LS_SE1;
      end else if (!dp_high && !dn_high) begin
         line_state = LS_SE0;
      end else if (full_speed) begin
         line_state = dp_high ? LS_J : LS_K;
      end else begin
         line_state = dp_high ? LS_K : LS_J;
      end
   end

   assign start_t = TIME_BITS'(sample_start);
   assign len_t   = TIME_BITS'(sample_len);

endmodule

// ===== rtl/core/lsseg_queue.sv =====
// ----------------------------------------------------------------------------
// Line-state segmenter word queue
// Small first-in first-out buffer between the classifier and the merge stage.
// ----------------------------------------------------------------------------
module lsseg_queue
   import lsseg_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             valid,
   output logic [WIDTH-1:0] head
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] FULL_CNT = COUNT_BITS'(DEPTH);

   logic [WIDTH-1:0]      entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   assign full  = count_ff == FULL_CNT;
   assign valid = count_ff != '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/lsseg_need_div.sv =====
// ----------------------------------------------------------------------------
// Glitch length divider
// Turns the glitch limit in picoseconds into a length in ticks,
// ceil(glitch_limit / tick), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsseg_need_div
   import lsseg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [TICK_BITS-1:0]   tick,
   input  logic [GLITCH_BITS-1:0] glitch,
   output logic                   busy,
   output need_type               need
);

   localparam int STEP_BITS = $clog2(GLITCH_BITS + 1);
   localparam logic [STEP_BITS-1:0] STEPS = STEP_BITS'(GLITCH_BITS);

   logic                   busy_ff;
   logic [STEP_BITS-1:0]   step_ff;
   logic [TICK_BITS-1:0]   rem_ff;
   logic [TICK_BITS-1:0]   rem_in;
   logic [GLITCH_BITS-1:0] quo_ff;
   logic [GLITCH_BITS-1:0] quo_in;
   need_type               need_ff;
   need_type               need_in;
   logic [TICK_BITS:0]     shifted;
   logic                   fits;

   // One restoring step: bring down the next dividend bit and try a subtract.
   assign shifted = {rem_ff, quo_ff[GLITCH_BITS-1]};
   assign fits    = shifted >= {1'b0, tick};

   always_comb begin
      rem_in = fits ? TICK_BITS'(shifted - {1'b0, tick}) : shifted[TICK_BITS-1:0];
      quo_in = {quo_ff[GLITCH_BITS-2:0], fits};
   end

   // A zero tick makes every length short; a zero limit makes none.
   always_comb begin
      need_in.always_short = (tick == '0) && (glitch != '0);
      if (glitch == '0) begin
         need_in.need = '0;
      end else begin
         need_in.need = {1'b0, quo_ff} + NEED_BITS'(rem_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         need_ff <= '{always_short: 1'b0, need: NEED_RESET};
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= STEPS;
      end else if (busy_ff) begin
         if (step_ff != '0) begin
            step_ff <= step_ff - 1'b1;
         end else begin
            busy_ff <= 1'b0;
            need_ff <= need_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= glitch;
      end else if (busy_ff && step_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy = start || busy_ff;
   assign need = need_ff;

endmodule

// ===== rtl/core/lsseg_back.sv =====
// ----------------------------------------------------------------------------
// Segment merge stage
// Holds the open segment, merges runs and short SE0/SE1 glitches, and
// registers finished segments for the result channel.
// ----------------------------------------------------------------------------
module lsseg_back
   import lsseg_pkg::*;
#(
   parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  logic                     q_action,
   input  line_state_type           q_state,
   input  logic [TIME_BITS-1:0]     q_start,
   input  logic [TIME_BITS-1:0]     q_len,
   input  need_type                 need,
   output logic                     q_pop,
   output back_status_type          status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SEG_PORT_BITS-1:0] rsp_seg_start,
   output logic [SEG_PORT_BITS-1:0] rsp_seg_len,
   output logic [1:0]               rsp_seg_state
);

   localparam int CMP_BITS = (TIME_BITS > NEED_BITS) ? TIME_BITS : NEED_BITS;

   logic                     open_valid_ff;
   logic [TIME_BITS-1:0]     open_start_ff;
   logic [TIME_BITS-1:0]     open_len_ff;
   line_state_type           open_state_ff;
   logic                     rsp_valid_ff;
   logic [SEG_PORT_BITS-1:0] rsp_start_ff;
   logic [SEG_PORT_BITS-1:0] rsp_len_ff;
   line_state_type           rsp_state_ff;

   logic                 flush;
   logic [TIME_BITS:0]   sum;
   logic [TIME_BITS-1:0] len_sat;
   logic                 open_is_glitch;
   logic                 open_short;
   logic                 emit;

   assign q_pop = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign flush = q_action == ACTION_FLUSH;

   assign sum     = {1'b0, open_len_ff} + {1'b0, q_len};
   assign len_sat = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

   assign open_is_glitch = (open_state_ff == LS_SE0) || (open_state_ff == LS_SE1);
   assign open_short     = need.always_short ||
                           (CMP_BITS'(open_len_ff) < CMP_BITS'(need.need));

   always_comb begin
      emit = 1'b0;
      if (q_pop && open_valid_ff) begin
         if (flush) begin
            emit = 1'b1;
         end else if (q_state != open_state_ff && !(open_is_glitch && open_short)) begin
            emit = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (q_pop) begin
            open_valid_ff <= !flush;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_start_ff <= SEG_PORT_BITS'(open_start_ff);
         rsp_len_ff   <= SEG_PORT_BITS'(open_len_ff);
         rsp_state_ff <= open_state_ff;
      end
      if (q_pop && !flush) begin
         open_state_ff <= q_state;
         if (!open_valid_ff || emit) begin
            open_start_ff <= q_start;
            open_len_ff   <= q_len;
         end else begin
            open_len_ff <= len_sat;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_seg_start = rsp_start_ff;
   assign rsp_seg_len   = rsp_len_ff;
   assign rsp_seg_state = rsp_state_ff;

   assign status = '{pop: q_pop, pop_flush: q_pop && flush, open_valid: open_valid_ff};

endmodule

// ===== rtl/core/usb_line_state_segmenter.sv =====
// ----------------------------------------------------------------------------
// USB line-state segmenter
// Classes D+/D- sample pairs as SE0, SE1, J or K and merges them into
// timed line-state segments, absorbing short SE0/SE1 glitches.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Contents
//   req_     in         req_valid/req_stall  sample pair or end-of-capture flush
//   rsp_     out        rsp_valid/rsp_stall  finished segment: start, length, state
//   csr_     in         csr_write_enable     speed mode, threshold, tick, glitch limit
//
// A word is classified in the cycle it is accepted and enters a two-entry
// queue; the merge stage takes one word per cycle from it while the result
// is not stalled, so the block runs at one word per clock into a result
// register unless stalled. Writing tick_ps or glitch_limit_ps starts a divide
// that turns the glitch limit into a length in ticks; req_stall stays high meanwhile.
// Reset is synchronous and active high and leaves no open segment.
// A stalled result only stops the merge stage; the queue keeps taking words
// until it fills.
//
module usb_line_state_segmenter
   import lsseg_pkg::*;
#(
   parameter int TIME_BITS  = DEFAULT_TIME_BITS,
   parameter int LEVEL_BITS = DEFAULT_LEVEL_BITS
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic signed [LEVEL_PORT_BITS-1:0] req_dp_level,
   input  logic signed [LEVEL_PORT_BITS-1:0] req_dn_level,
   input  logic [START_PORT_BITS-1:0]        req_sample_start,
   input  logic [LEN_PORT_BITS-1:0]          req_sample_len,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [SEG_PORT_BITS-1:0]          rsp_seg_start,
   output logic [SEG_PORT_BITS-1:0]          rsp_seg_len,
   output logic [1:0]                        rsp_seg_state,

   input  logic                              csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [CSR_DATA_BITS-1:0]          csr_wdata
);

   // Queue word layout: action, class, start, length.
   localparam int ITEM_BITS = 1 + 2 + 2 * TIME_BITS;

   // Configuration registers.
   logic                      full_speed_ff;
   logic [THRESHOLD_BITS-1:0] threshold_ff;
   logic [TICK_BITS-1:0]      tick_ff;
   logic [GLITCH_BITS-1:0]    glitch_ff;
   logic                      div_start_ff;

   logic     div_busy;
   need_type need;

   line_state_type       front_state;
   logic [TIME_BITS-1:0] front_start;
   logic [TIME_BITS-1:0] front_len;

   logic                 q_push;
   logic                 q_full;
   logic                 q_valid;
   logic                 q_pop;
   logic [ITEM_BITS-1:0] q_push_data;
   logic [ITEM_BITS-1:0] q_head;
   logic                 q_action;
   line_state_type       q_state;
   logic [TIME_BITS-1:0] q_start;
   logic [TIME_BITS-1:0] q_len;

   back_status_type back_status;

   // Configuration writes. A change of tick or glitch limit reloads the
   // divider in the following cycle, once the new value is in its register.
   always_ff @(posedge clock) begin
      if (reset) begin
         full_speed_ff <= FULL_SPEED_RESET;
         threshold_ff  <= THRESHOLD_RESET;
         tick_ff       <= TICK_RESET;
         glitch_ff     <= GLITCH_RESET;
         div_start_ff  <= 1'b0;
      end else begin
         div_start_ff <= csr_write_enable &&
                         (csr_index == CSR_TICK || csr_index == CSR_GLITCH);
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FULL_SPEED: begin
                  full_speed_ff <= csr_wdata[0];
               end
               CSR_THRESHOLD: begin
                  threshold_ff <= csr_wdata[THRESHOLD_BITS-1:0];
               end
               CSR_TICK: begin
                  tick_ff <= csr_wdata[TICK_BITS-1:0];
               end
               CSR_GLITCH: begin
                  glitch_ff <= csr_wdata[GLITCH_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   lsseg_need_div u_need_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start_ff),
      .tick   (tick_ff),
      .glitch (glitch_ff),
      .busy   (div_busy),
      .need   (need)
   );

   // Front: classify the accepted word and queue it.
   lsseg_front #(
      .TIME_BITS  (TIME_BITS),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_front (
      .dp_level     (req_dp_level),
      .dn_level     (req_dn_level),
      .threshold    (threshold_ff),
      .full_speed   (full_speed_ff),
      .sample_start (req_sample_start),
      .sample_len   (req_sample_len),
      .line_state   (front_state),
      .start_t      (front_start),
      .len_t        (front_len)
   );

   assign req_stall   = q_full || div_busy;
   assign q_push      = req_valid && !req_stall;
   assign q_push_data = {req_action, front_state, front_start, front_len};

   lsseg_queue #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .head      (q_head)
   );

   assign q_action = q_head[ITEM_BITS-1];
   assign q_state  = line_state_type'(q_head[ITEM_BITS-2 -: 2]);
   assign q_start  = q_head[2*TIME_BITS-1 -: TIME_BITS];
   assign q_len    = q_head[TIME_BITS-1:0];

   // Back: merge runs into the open segment and emit finished ones.
   lsseg_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_action      (q_action),
      .q_state       (q_state),
      .q_start       (q_start),
      .q_len         (q_len),
      .need          (need),
      .q_pop         (q_pop),
      .status        (back_status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_seg_start (rsp_seg_start),
      .rsp_seg_len   (rsp_seg_len),
      .rsp_seg_state (rsp_seg_state)
   );

   // A new result must come from a word the merge stage took in the previous cycle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(back_status.pop))
      else $error("result appeared without a merged word");

   // A queued word is visible to the merge stage on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      q_push |=> q_valid)
      else $error("accepted word missing from queue");

   // An end-of-capture flush leaves no open segment behind.
   assert property (@(posedge clock) disable iff (reset)
      back_status.pop_flush |=> !back_status.open_valid)
      else $error("open segment survived a flush");

endmodule
